@@ hw/rtl/lspg_pkg.sv @@
// Shared types, constants and the sine table of the LED status pattern generator.
// Used by every module under hw/rtl; depends on nothing else.
package lspg_pkg;

    // Fixed by the field widths of the channels
    localparam int ELAPSED_W      = 10;
    localparam int PHASE_W        = 11;
    localparam int POS_W          = 10;
    localparam int DUTY_W         = 13;
    localparam int IN_TDATA_W     = 16;
    localparam int OUT_TDATA_W    = 16;
    localparam int CFG_INDEX_W    = 1;
    localparam int CFG_DATA_W     = 3;

    localparam int DUTY_MAX       = 8191;
    localparam int SINE_ENTRIES   = 256;
    localparam int DUTY_FIELD_MAX = 8191;

    localparam int PERIOD_MS      = 2000;
    localparam int HALF_MS        = 1000;
    localparam int CONNECT_MS     = 500;
    localparam int CONNECT_ON_MS  = 250;
    localparam int ERROR_STEP_MS  = 100;
    localparam int BEAT1_END_MS   = 150;
    localparam int BEAT2_START_MS = 250;
    localparam int BEAT2_END_MS   = 350;
    localparam int BEAT2_SPAN_MS  = BEAT2_END_MS - BEAT2_START_MS;

    // Sine table: Q15, entry k = sin(pi*k/N)
    localparam int SINE_W  = 16;
    localparam int S_W     = SINE_W + 1;
    localparam int IDX_W   = $clog2(SINE_ENTRIES);
    localparam logic [S_W-1:0] Q15_ONE = S_W'(32768);
    localparam longint unsigned PI_Q30 = 64'd3373259426;

    // Index = pos*N/span through a reciprocal; exact while pos*span < 2^IDX_SHIFT
    localparam int IDX_SHIFT = 24;
    localparam int RECIP_W   = IDX_W + IDX_SHIFT - 5;
    localparam int IDX_PROD_W = POS_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_IDLE = RECIP_W'(
        (longint'(SINE_ENTRIES) * (64'd1 << IDX_SHIFT) + HALF_MS - 1) / HALF_MS);
    localparam logic [RECIP_W-1:0] RECIP_BEAT1 = RECIP_W'(
        (longint'(SINE_ENTRIES) * (64'd1 << IDX_SHIFT) + BEAT1_END_MS - 1) / BEAT1_END_MS);
    localparam logic [RECIP_W-1:0] RECIP_BEAT2 = RECIP_W'(
        (longint'(SINE_ENTRIES) * (64'd1 << IDX_SHIFT) + BEAT2_SPAN_MS - 1) / BEAT2_SPAN_MS);

    // Duty scaling
    localparam int MULT_W = $clog2(2 * DUTY_MAX + 1);
    localparam int PROD_W = S_W + MULT_W;
    localparam logic [MULT_W-1:0] MULT_BEAT = MULT_W'(DUTY_MAX);
    localparam logic [MULT_W-1:0] MULT_IDLE = MULT_W'(2 * DUTY_MAX);
    localparam logic [DUTY_W-1:0] DUTY_FULL =
        (DUTY_MAX > DUTY_FIELD_MAX) ? DUTY_W'(DUTY_FIELD_MAX) : DUTY_W'(DUTY_MAX);

    // Idle divide by 5 after the >>16, reciprocal with correction-free width
    localparam int Y_W        = PROD_W - 16;
    localparam int DIV5_SHIFT = Y_W + 3;
    localparam int DIV5_W     = Y_W + 1;
    localparam logic [DIV5_W-1:0] DIV5_RECIP =
        DIV5_W'(((64'd1 << DIV5_SHIFT) + 4) / 5);

    typedef enum logic [2:0] {
        MODE_OFF        = 3'd0,
        MODE_UPDATE     = 3'd1,
        MODE_CONNECTING = 3'd2,
        MODE_IDLE       = 3'd3,
        MODE_STREAMING  = 3'd4,
        MODE_ERROR      = 3'd5
    } led_mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LED_MODE = 1'd0,
        REG_ENABLE   = 1'd1
    } reg_index_t;

    typedef enum logic [2:0] {
        KIND_ZERO,
        KIND_FULL,
        KIND_IDLE,
        KIND_BEAT_HI,
        KIND_BEAT_LO
    } kind_t;

    typedef struct packed {
        kind_t            kind;
        logic             half;
        logic [IDX_W-1:0] idx;
    } index_item_t;

    typedef struct packed {
        kind_t             kind;
        logic [PROD_W-1:0] prod;
    } shape_item_t;

    typedef logic [SINE_ENTRIES-1:0][SINE_W-1:0] sine_table_t;

    // Taylor series in unsigned Q30, seven terms, rounded to Q15
    function automatic sine_table_t build_sine_table();
        sine_table_t     tbl;
        longint unsigned kk;
        longint unsigned a;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned r;
        tbl = '0;
        for (int k = 0; k < SINE_ENTRIES; k++)
        begin
            kk = (2 * k > SINE_ENTRIES) ? longint'(SINE_ENTRIES - k) : longint'(k);
            a = (PI_Q30 * kk) / SINE_ENTRIES;
            term = a;
            sum = a;
            term = (((term * a) >> 30) * a) >> 30;
            term = term / 6;
            sum = (sum > term) ? (sum - term) : 64'd0;
            term = (((term * a) >> 30) * a) >> 30;
            term = term / 20;
            sum = sum + term;
            term = (((term * a) >> 30) * a) >> 30;
            term = term / 42;
            sum = (sum > term) ? (sum - term) : 64'd0;
            term = (((term * a) >> 30) * a) >> 30;
            term = term / 72;
            sum = sum + term;
            term = (((term * a) >> 30) * a) >> 30;
            term = term / 110;
            sum = (sum > term) ? (sum - term) : 64'd0;
            term = (((term * a) >> 30) * a) >> 30;
            term = term / 156;
            sum = sum + term;
            r = (sum + (64'd1 << 14)) >> 15;
            if (r > 64'd32768)
            begin
                r = 64'd32768;
            end
            tbl[k] = SINE_W'(r);
        end
        return tbl;
    endfunction

    localparam sine_table_t SINE_TABLE = build_sine_table();

endpackage

@@ hw/rtl/lspg_phase.sv @@
// Input stage: takes tick items, advances the millisecond phase, registers it.
// Depends on lspg_pkg.
module lspg_phase
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           enable,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [lspg_pkg::ELAPSED_W-1:0] elapsed_ms,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [lspg_pkg::PHASE_W-1:0]   phase
);

    logic                         valid_reg;
    logic [lspg_pkg::PHASE_W-1:0] phase_reg;
    logic [lspg_pkg::PHASE_W-1:0] phase_next;
    logic [lspg_pkg::PHASE_W-1:0] stage_phase_reg;
    logic [lspg_pkg::PHASE_W:0]   sum;
    logic                         accept;

    assign in_ready = !valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        sum = {1'b0, phase_reg} + (lspg_pkg::PHASE_W + 1)'(elapsed_ms);
        if (sum >= (lspg_pkg::PHASE_W + 1)'(lspg_pkg::PERIOD_MS))
        begin
            sum = sum - (lspg_pkg::PHASE_W + 1)'(lspg_pkg::PERIOD_MS);
        end
        phase_next = sum[lspg_pkg::PHASE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg <= phase_next;
            end
            if (in_ready)
            begin
                // disabled ticks move the phase but leave no item behind
                valid_reg <= in_valid && enable;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_phase_reg <= phase_next;
        end
    end

    assign out_valid = valid_reg;
    assign phase     = stage_phase_reg;

    a_phase_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg < lspg_pkg::PHASE_W'(lspg_pkg::PERIOD_MS))
        else $error("phase left its period");

    a_enabled_tick_kept: assert property (@(posedge clk) disable iff (!rst_n)
        accept && enable |=> valid_reg && (stage_phase_reg == phase_reg))
        else $error("enabled tick lost or phase copy out of step");

endmodule

@@ hw/rtl/lspg_index.sv @@
// Pattern decode: picks the waveform segment for the mode and forms the table index.
// Depends on lspg_pkg.
module lspg_index
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [2:0]                    led_mode,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [lspg_pkg::PHASE_W-1:0]  phase,
    output logic                          out_valid,
    input  logic                          out_ready,
    output lspg_pkg::index_item_t         item
);

    logic                            valid_reg;
    lspg_pkg::index_item_t           item_reg;
    lspg_pkg::index_item_t           item_next;
    logic                            half;
    logic [lspg_pkg::POS_W-1:0]      pos;
    logic [lspg_pkg::POS_W-1:0]      pos_500;
    logic [lspg_pkg::POS_W-1:0]      num;
    logic [lspg_pkg::RECIP_W-1:0]    recip;
    logic [lspg_pkg::IDX_PROD_W-1:0] idx_prod;
    logic                            hundreds_odd;
    lspg_pkg::kind_t                 kind;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        half = phase >= lspg_pkg::PHASE_W'(lspg_pkg::HALF_MS);
        pos  = half ? lspg_pkg::POS_W'(phase - lspg_pkg::PHASE_W'(lspg_pkg::HALF_MS))
                    : phase[lspg_pkg::POS_W-1:0];
        pos_500 = (pos >= lspg_pkg::POS_W'(lspg_pkg::CONNECT_MS))
                ? pos - lspg_pkg::POS_W'(lspg_pkg::CONNECT_MS) : pos;

        // error blinks on even hundreds of ms
        hundreds_odd = 1'b0;
        for (int j = 1; j < 10; j++)
        begin
            hundreds_odd = hundreds_odd ^ (pos >= lspg_pkg::POS_W'(lspg_pkg::ERROR_STEP_MS * j));
        end

        kind  = lspg_pkg::KIND_ZERO;
        num   = pos;
        recip = lspg_pkg::RECIP_IDLE;
        unique case (lspg_pkg::led_mode_t'(led_mode))
            lspg_pkg::MODE_CONNECTING:
            begin
                kind = (pos_500 < lspg_pkg::POS_W'(lspg_pkg::CONNECT_ON_MS))
                     ? lspg_pkg::KIND_FULL : lspg_pkg::KIND_ZERO;
            end
            lspg_pkg::MODE_IDLE:
            begin
                kind = lspg_pkg::KIND_IDLE;
            end
            lspg_pkg::MODE_STREAMING:
            begin
                if (pos < lspg_pkg::POS_W'(lspg_pkg::BEAT1_END_MS))
                begin
                    kind  = lspg_pkg::KIND_BEAT_HI;
                    recip = lspg_pkg::RECIP_BEAT1;
                end
                else if (pos >= lspg_pkg::POS_W'(lspg_pkg::BEAT2_START_MS) &&
                         pos <  lspg_pkg::POS_W'(lspg_pkg::BEAT2_END_MS))
                begin
                    kind  = lspg_pkg::KIND_BEAT_LO;
                    num   = pos - lspg_pkg::POS_W'(lspg_pkg::BEAT2_START_MS);
                    recip = lspg_pkg::RECIP_BEAT2;
                end
            end
            lspg_pkg::MODE_ERROR:
            begin
                kind = hundreds_odd ? lspg_pkg::KIND_ZERO : lspg_pkg::KIND_FULL;
            end
            default:
            begin
                kind = lspg_pkg::KIND_ZERO;
            end
        endcase

        idx_prod = lspg_pkg::IDX_PROD_W'(num) * lspg_pkg::IDX_PROD_W'(recip);
        item_next.kind = kind;
        item_next.half = half;
        item_next.idx  = idx_prod[lspg_pkg::IDX_SHIFT +: lspg_pkg::IDX_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign item      = item_reg;

    a_index_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && (item_reg.kind == lspg_pkg::KIND_IDLE ||
                      item_reg.kind == lspg_pkg::KIND_BEAT_HI ||
                      item_reg.kind == lspg_pkg::KIND_BEAT_LO)
        |-> (32'(item_reg.idx) < lspg_pkg::SINE_ENTRIES))
        else $error("sine index beyond table");

endmodule

@@ hw/rtl/lspg_shape.sv @@
// Table stage: reads the sine value, offsets it for breathing and scales by the duty range.
// Depends on lspg_pkg.
module lspg_shape
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  lspg_pkg::index_item_t in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output lspg_pkg::shape_item_t out_item
);

    logic                          valid_reg;
    lspg_pkg::shape_item_t         item_reg;
    lspg_pkg::shape_item_t         item_next;
    logic [lspg_pkg::SINE_W-1:0]   sine;
    logic [lspg_pkg::S_W-1:0]      level;
    logic [lspg_pkg::MULT_W-1:0]   mult;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        sine = lspg_pkg::SINE_TABLE[in_item.idx];
        if (in_item.kind == lspg_pkg::KIND_IDLE)
        begin
            // second half of the period runs the sine below mid level
            level = in_item.half ? lspg_pkg::Q15_ONE - lspg_pkg::S_W'(sine)
                                 : lspg_pkg::Q15_ONE + lspg_pkg::S_W'(sine);
            mult  = lspg_pkg::MULT_IDLE;
        end
        else
        begin
            level = lspg_pkg::S_W'(sine);
            mult  = lspg_pkg::MULT_BEAT;
        end
        item_next.kind = in_item.kind;
        item_next.prod = lspg_pkg::PROD_W'(level) * lspg_pkg::PROD_W'(mult);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

@@ hw/rtl/lspg_scale.sv @@
// Output stage: final shift or divide by five, saturation, and the duty output register.
// Depends on lspg_pkg.
module lspg_scale
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  lspg_pkg::shape_item_t       in_item,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [lspg_pkg::DUTY_W-1:0] duty
);

    localparam int QP_W = lspg_pkg::Y_W + lspg_pkg::DIV5_W;

    logic                          valid_reg;
    logic [lspg_pkg::DUTY_W-1:0]   duty_reg;
    logic [lspg_pkg::DUTY_W-1:0]   duty_next;
    logic [lspg_pkg::Y_W-1:0]      y;
    logic [QP_W-1:0]               q_prod;
    logic [lspg_pkg::PROD_W-1:0]   value;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        y      = in_item.prod[lspg_pkg::PROD_W-1:16];
        q_prod = QP_W'(y) * QP_W'(lspg_pkg::DIV5_RECIP);
        case (in_item.kind)
            lspg_pkg::KIND_IDLE:
            begin
                value = lspg_pkg::PROD_W'(q_prod >> lspg_pkg::DIV5_SHIFT);
            end
            lspg_pkg::KIND_BEAT_HI:
            begin
                value = in_item.prod >> 15;
            end
            lspg_pkg::KIND_BEAT_LO:
            begin
                value = in_item.prod >> 16;
            end
            lspg_pkg::KIND_FULL:
            begin
                value = lspg_pkg::PROD_W'(lspg_pkg::DUTY_FULL);
            end
            default:
            begin
                value = '0;
            end
        endcase
        duty_next = (value > lspg_pkg::PROD_W'(lspg_pkg::DUTY_FIELD_MAX))
                  ? lspg_pkg::DUTY_W'(lspg_pkg::DUTY_FIELD_MAX)
                  : value[lspg_pkg::DUTY_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            duty_reg <= duty_next;
        end
    end

    assign out_valid = valid_reg;
    assign duty      = duty_reg;

endmodule

@@ hw/rtl/led_status_pattern_generator.sv @@
// LED status pattern generator: top level, configuration registers and stage chain.
// Depends on lspg_pkg, lspg_phase, lspg_index, lspg_shape, lspg_scale.
//
// Usage:
//   s_axis carries tick items; tdata[9:0] is the milliseconds elapsed since the
//   previous tick. m_axis carries one duty item per tick while enabled;
//   tdata[12:0] is the PWM duty, 8191 fully on.
//   cfg_we/cfg_index/cfg_data write led_mode (index 0) and enable (index 1);
//   write them only while no tick is in flight.
//   Every tick advances the 2000 ms phase; disabled ticks give no output item.
//   An accepted tick passes the phase register, the index multiply, the table and
//   scaling multiply and the output register before its duty item is on m_axis.
//   Throughput: one tick per cycle while m_axis_tready stays high, set by the
//   four-stage pipeline in which every stage holds one item.
//   Each stage has its own valid bit, so a stalled receiver holds the output
//   register while empty stages upstream keep taking ticks; s_axis_tready
//   drops only once every stage is full.
//   Reset clears the phase to 0, the mode to off, enable to 0 and empties the
//   pipeline; no sweep is needed.
module led_status_pattern_generator
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [lspg_pkg::IN_TDATA_W-1:0]   s_axis_tdata,   // [9:0] elapsed_ms
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [lspg_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,   // [12:0] duty
    input  logic                              cfg_we,
    input  logic [lspg_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [lspg_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic [2:0]                     led_mode_reg;
    logic                           enable_reg;

    logic                           phase_valid;
    logic                           phase_ready;
    logic [lspg_pkg::PHASE_W-1:0]   phase;
    logic                           index_valid;
    logic                           index_ready;
    lspg_pkg::index_item_t          index_item;
    logic                           shape_valid;
    logic                           shape_ready;
    lspg_pkg::shape_item_t          shape_item;
    logic [lspg_pkg::DUTY_W-1:0]    duty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_mode_reg <= lspg_pkg::MODE_OFF;
            enable_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (lspg_pkg::reg_index_t'(cfg_index))
                lspg_pkg::REG_LED_MODE:
                begin
                    led_mode_reg <= cfg_data[2:0];
                end
                lspg_pkg::REG_ENABLE:
                begin
                    enable_reg <= cfg_data[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    lspg_phase u_phase
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .enable     (enable_reg),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .elapsed_ms (s_axis_tdata[lspg_pkg::ELAPSED_W-1:0]),
        .out_valid  (phase_valid),
        .out_ready  (phase_ready),
        .phase      (phase)
    );

    lspg_index u_index
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .led_mode  (led_mode_reg),
        .in_valid  (phase_valid),
        .in_ready  (phase_ready),
        .phase     (phase),
        .out_valid (index_valid),
        .out_ready (index_ready),
        .item      (index_item)
    );

    lspg_shape u_shape
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (index_valid),
        .in_ready  (index_ready),
        .in_item   (index_item),
        .out_valid (shape_valid),
        .out_ready (shape_ready),
        .out_item  (shape_item)
    );

    lspg_scale u_scale
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (shape_valid),
        .in_ready  (shape_ready),
        .in_item   (shape_item),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .duty      (duty)
    );

    assign m_axis_tdata = {{(lspg_pkg::OUT_TDATA_W - lspg_pkg::DUTY_W){1'b0}}, duty};

    a_full_duty_held: assert property (@(posedge clk) disable iff (!rst_n)
        shape_valid && shape_ready && shape_item.kind == lspg_pkg::KIND_FULL
        |=> m_axis_tvalid && (duty == lspg_pkg::DUTY_FULL))
        else $error("square wave on-level not delivered");

endmodule
